@@ hw/rtl/spr_pkg.sv @@
package spr_pkg;

  localparam int PACKET_BYTES = 1024;
  localparam int POS_W        = 10;
  localparam int SUM_W        = 18;
  localparam int SUM_WORD_POS = 30;
  localparam int SEQ_WORD_POS = 26;

  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] SUM_END_POS = POS_W'(PACKET_BYTES - 2);
  localparam logic [POS_W-1:0] CKSUM_LO    = POS_W'(SUM_WORD_POS);
  localparam logic [POS_W-1:0] CKSUM_HI    = POS_W'(SUM_WORD_POS + 4);
  localparam logic [POS_W-1:0] SEQNO_LO    = POS_W'(SEQ_WORD_POS);
  localparam logic [POS_W-1:0] SEQNO_HI    = POS_W'(SEQ_WORD_POS + 4);

  // verdict codes
  localparam logic [1:0] VERDICT_NEW = 2'd0;
  localparam logic [1:0] VERDICT_DUP = 2'd1;
  localparam logic [1:0] VERDICT_BAD = 2'd2;

  // sequence classes
  localparam logic [2:0] SEQ_FIRST     = 3'd0;
  localparam logic [2:0] SEQ_NEXT      = 3'd1;
  localparam logic [2:0] SEQ_JUMP      = 3'd2;
  localparam logic [2:0] SEQ_BACK      = 3'd3;
  localparam logic [2:0] SEQ_UNCHECKED = 3'd4;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [POS_W-1:0] byte_index;
    logic             last_byte;
    logic [1:0]       verdict;
    logic             reply_nak;
    logic [31:0]      sequence_number;
    logic [2:0]       sequence_class;
    logic [15:0]      dropped_bytes;
  } res_t;

  typedef struct packed {
    logic first_vld;
    logic second_vld;
    res_t first;
    res_t second;
  } push_t;

endpackage

@@ hw/rtl/spr_if.sv @@
interface spr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spr_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [9:0]  byte_index;
  logic        last_byte;
  logic [1:0]  verdict;
  logic        reply_nak;
  logic [31:0] sequence_number;
  logic [2:0]  sequence_class;
  logic [15:0] dropped_bytes;

  modport source (output valid, output out_byte, output byte_index, output last_byte,
                  output verdict, output reply_nak, output sequence_number,
                  output sequence_class, output dropped_bytes, input ready);
  modport sink   (input valid, input out_byte, input byte_index, input last_byte,
                  input verdict, input reply_nak, input sequence_number,
                  input sequence_class, input dropped_bytes, output ready);
endinterface

@@ hw/rtl/spr_framer.sv @@
module spr_framer (
  input  logic           clk_i,
  input  logic           rst_ni,
  spr_rx_if.sink         rx,
  input  logic           room_i,
  input  logic           flag_i,
  output spr_pkg::push_t push_o
);

  logic                       stage_vld_q, stage_vld_d;
  logic [7:0]                 byte_q, byte_d;
  logic                       receiving_q, receiving_d;
  logic [7:0]                 held_q, held_d;
  logic                       have_held_q, have_held_d;
  logic [spr_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [spr_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [31:0]                exp_q, exp_d;
  logic [31:0]                seq_q, seq_d;
  logic [31:0]                prev_q, prev_d;
  logic                       have_prev_q, have_prev_d;
  logic [15:0]                drop_q, drop_d;

  logic accept, advance;
  logic in_sum, in_seq, in_exp, is_last, sum_ok;
  spr_pkg::res_t res;

  function automatic spr_pkg::res_t plain_res(logic [7:0] b,
                                              logic [spr_pkg::POS_W-1:0] pos,
                                              logic [15:0] drop);
    spr_pkg::res_t r;
    r                 = '0;
    r.out_byte        = b;
    r.byte_index      = pos;
    r.dropped_bytes   = drop;
    return r;
  endfunction

  assign accept   = rx.valid && rx.ready;
  assign advance  = stage_vld_q && room_i;
  assign rx.ready = !stage_vld_q || room_i;

  assign in_sum  = (pos_q < spr_pkg::CKSUM_LO) ||
                   (pos_q >= spr_pkg::CKSUM_HI && pos_q < spr_pkg::SUM_END_POS);
  assign in_seq  = (pos_q >= spr_pkg::SEQNO_LO) && (pos_q < spr_pkg::SEQNO_HI);
  assign in_exp  = (pos_q >= spr_pkg::CKSUM_LO) && (pos_q < spr_pkg::CKSUM_HI);
  assign is_last = (pos_q == spr_pkg::LAST_POS);
  assign sum_ok  = ({{(32 - spr_pkg::SUM_W){1'b0}}, sum_q} == exp_q);

  always_comb begin
    stage_vld_d = stage_vld_q;
    byte_d      = byte_q;
    receiving_d = receiving_q;
    held_d      = held_q;
    have_held_d = have_held_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    exp_d       = exp_q;
    seq_d       = seq_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    drop_d      = drop_q;
    push_o      = '0;
    res         = plain_res(byte_q, pos_q, drop_q);

    if (advance) begin
      stage_vld_d = 1'b0;
    end
    if (accept) begin
      stage_vld_d = 1'b1;
      byte_d      = rx.rx_byte;
    end

    if (advance) begin
      if (receiving_q) begin
        if (in_sum) sum_d = sum_q + {{(spr_pkg::SUM_W - 8){1'b0}}, byte_q};
        if (in_seq) seq_d = {seq_q[23:0], byte_q};
        if (in_exp) exp_d = {exp_q[23:0], byte_q};
        pos_d = pos_q + 1'b1;
        if (is_last) begin
          res.out_byte        = {7'd0, flag_i};
          res.last_byte       = 1'b1;
          res.sequence_number = seq_q;
          if (!sum_ok) begin
            res.verdict        = spr_pkg::VERDICT_BAD;
            res.reply_nak      = 1'b1;
            res.sequence_class = spr_pkg::SEQ_UNCHECKED;
          end else begin
            if (!have_prev_q) begin
              res.sequence_class = spr_pkg::SEQ_FIRST;
            end else if (seq_q == prev_q + 32'd1 || seq_q == prev_q) begin
              res.sequence_class = spr_pkg::SEQ_NEXT;
            end else if (seq_q < prev_q) begin
              res.sequence_class = spr_pkg::SEQ_BACK;
            end else begin
              res.sequence_class = spr_pkg::SEQ_JUMP;
            end
            if (have_prev_q && seq_q == prev_q) begin
              res.verdict = spr_pkg::VERDICT_DUP;
            end else begin
              res.verdict = spr_pkg::VERDICT_NEW;
              prev_d      = seq_q;
              have_prev_d = 1'b1;
            end
          end
          // back to hunting with a clean slate
          receiving_d = 1'b0;
          have_held_d = 1'b0;
          held_d      = '0;
          pos_d       = '0;
          sum_d       = '0;
          exp_d       = '0;
          seq_d       = '0;
          drop_d      = '0;
        end
        push_o.first_vld = 1'b1;
        push_o.first     = res;
      end else if (have_held_q && byte_q == ~held_q) begin
        // sync pair: both bytes open the packet at index 0 and 1
        receiving_d       = 1'b1;
        have_held_d       = 1'b0;
        push_o.first_vld  = 1'b1;
        push_o.second_vld = 1'b1;
        push_o.first      = plain_res(held_q, '0, drop_q);
        push_o.second     = plain_res(byte_q, spr_pkg::POS_W'(1), drop_q);
        sum_d             = {{(spr_pkg::SUM_W - 8){1'b0}}, held_q} +
                            {{(spr_pkg::SUM_W - 8){1'b0}}, byte_q};
        pos_d             = spr_pkg::POS_W'(2);
      end else begin
        if (have_held_q && drop_q != 16'hFFFF) drop_d = drop_q + 16'd1;
        held_d      = byte_q;
        have_held_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      receiving_q <= 1'b0;
      held_q      <= '0;
      have_held_q <= 1'b0;
      pos_q       <= '0;
      sum_q       <= '0;
      exp_q       <= '0;
      seq_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      drop_q      <= '0;
    end else begin
      stage_vld_q <= stage_vld_d;
      receiving_q <= receiving_d;
      held_q      <= held_d;
      have_held_q <= have_held_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      exp_q       <= exp_d;
      seq_q       <= seq_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      drop_q      <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

@@ hw/rtl/spr_fifo.sv @@
module spr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spr_pkg::push_t push_i,
  output logic           room_o,
  spr_res_if.source      tx
);

  spr_pkg::res_t                  mem_q [spr_pkg::FIFO_DEPTH];
  logic [spr_pkg::FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [spr_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [spr_pkg::FIFO_CNT_W-1:0] n_push;
  logic                           pop;
  spr_pkg::res_t                  head;

  // room for a two-item burst from a sync pair
  assign room_o  = (cnt_q <= spr_pkg::FIFO_CNT_W'(spr_pkg::FIFO_DEPTH - 2));
  assign pop     = tx.valid && tx.ready;
  assign n_push  = spr_pkg::FIFO_CNT_W'(push_i.first_vld) +
                   spr_pkg::FIFO_CNT_W'(push_i.second_vld);
  assign wr_next = wr_q + 1'b1;
  assign wr_d    = wr_q + n_push[spr_pkg::FIFO_PTR_W-1:0];
  assign rd_d    = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d   = cnt_q + n_push - spr_pkg::FIFO_CNT_W'(pop);
  assign head    = mem_q[rd_q];

  assign tx.valid           = (cnt_q != '0);
  assign tx.out_byte        = head.out_byte;
  assign tx.byte_index      = head.byte_index;
  assign tx.last_byte       = head.last_byte;
  assign tx.verdict         = head.verdict;
  assign tx.reply_nak       = head.reply_nak;
  assign tx.sequence_number = head.sequence_number;
  assign tx.sequence_class  = head.sequence_class;
  assign tx.dropped_bytes   = head.dropped_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) mem_q[wr_q] <= push_i.first;
    if (push_i.second_vld) mem_q[wr_next] <= push_i.second;
  end

endmodule

@@ hw/rtl/sync_packet_receiver_core.sv @@
// sync_packet_receiver_core: serial packet framer
//
// in_i carries one received byte per item (valid/ready). while hunting, the
// block holds the last byte and waits for a byte equal to its complement;
// that pair opens a packet of spr_pkg::PACKET_BYTES bytes. every packet byte
// leaves on out_o with its index; the final byte carries the public-data
// flag and the verdict: checksum check (unsigned sum over the header and
// payload against the big-endian word at byte 30), sequence number class,
// duplicate mark and ACK/NAK. hunting bytes produce no output item.
// cfg_we_i/cfg_wdata_i write the public-data flag; write only while idle.
// timing: an accepted byte is held in the input register, then its
// results are written into a four-entry output queue, which offers them
// on out_o. one byte per cycle is sustained while the queue has room;
// the sync byte yields two items in the same cycle, which the queue absorbs.
// when out_o stalls, the queue fills; once fewer than two queue entries are
// free and the input register holds a byte, in_i drops ready, so nothing
// is lost.
// reset clears framing state, the previous sequence number and the flag;
// no clearing pass is needed, the block takes items right after reset.
module sync_packet_receiver_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  spr_rx_if.sink    in_i,
  spr_res_if.source out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic           flag_q;
  logic           room;
  spr_pkg::push_t push;

  // public-data flag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cfg_we_i) begin
      flag_q <= cfg_wdata_i;
    end
  end

  // input register plus framing, checksum and sequence logic
  spr_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (in_i),
    .room_i (room),
    .flag_i (flag_q),
    .push_o (push)
  );

  // result queue toward the output channel
  spr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tx     (out_o)
  );

endmodule
